### src/vfr_pkg.sv
`timescale 1ns / 1ps

package vfr_pkg;

  localparam logic [7:0] CMD_START_STOP = 8'h01;
  localparam logic [7:0] CMD_SENSOR     = 8'h02;
  localparam logic [7:0] STAMP_WRAP     = 8'hFF;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_STEP       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_LIMIT      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_TOLERANCE   = 3'd5;

  localparam logic [15:0] UPPER_THRESHOLD_RST  = 16'd6759;
  localparam logic [15:0] LOWER_THRESHOLD_RST  = 16'd5529;
  localparam logic [7:0]  TICKS_PER_WINDOW_RST = 8'd200;
  localparam logic [7:0]  DRIVE_STEP_RST       = 8'd2;
  localparam logic [9:0]  DRIVE_LIMIT_RST      = 10'd622;
  localparam logic [7:0]  BAND_TOLERANCE_RST   = 8'd1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command_byte;
    logic [15:0] accel_sample;
  } vfr_in_t;

  typedef struct packed {
    logic        report_kind;
    logic [7:0]  stamp_high;
    logic [7:0]  stamp_mid;
    logic [7:0]  stamp_low;
    logic [15:0] sample_echo;
    logic [7:0]  measured_frequency;
    logic [9:0]  drive_compare;
  } vfr_out_t;

  typedef struct packed {
    logic [15:0] upper_threshold;
    logic [15:0] lower_threshold;
    logic [7:0]  ticks_per_window;
    logic [7:0]  drive_step;
    logic [9:0]  drive_limit;
    logic [7:0]  band_tolerance;
  } vfr_cfg_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_RUN_CTRL = 2'd1,
    OP_SENSOR   = 2'd2,
    OP_TARGET   = 2'd3
  } vfr_op_t;

  typedef struct packed {
    vfr_op_t     op;
    logic [7:0]  command_byte;
    logic [15:0] accel_sample;
  } vfr_entry_t;

endpackage

### src/vfr_front.sv
`timescale 1ns / 1ps

module vfr_front (
  input  vfr_pkg::vfr_in_t    in_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output vfr_pkg::vfr_entry_t q_entry
);
  import vfr_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.command_byte = in_data.command_byte;
    q_entry.accel_sample = in_data.accel_sample;
    if (!in_data.kind) begin
      q_entry.op = OP_TICK;
    end else begin
      unique case (in_data.command_byte)
        CMD_START_STOP: q_entry.op = OP_RUN_CTRL;
        CMD_SENSOR:     q_entry.op = OP_SENSOR;
        default:        q_entry.op = OP_TARGET;
      endcase
    end
  end

endmodule

### src/vfr_queue.sv
`timescale 1ns / 1ps

module vfr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vfr_pkg::vfr_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output vfr_pkg::vfr_entry_t head_entry
);
  import vfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vfr_entry_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("word popped from empty queue");

endmodule

### src/vfr_back.sv
`timescale 1ns / 1ps

module vfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vfr_pkg::vfr_cfg_t   cfg,
  input  logic                head_valid,
  input  vfr_pkg::vfr_entry_t head_entry,
  output logic                pop,
  output vfr_pkg::vfr_out_t   out_data,
  output logic                out_valid,
  input  logic                out_stall
);
  import vfr_pkg::*;

  logic       running_r, running_nxt;
  logic       armed_r, armed_nxt;
  logic       pending_r, pending_nxt;
  logic [7:0] stamp_low_r, stamp_low_nxt;
  logic [7:0] stamp_mid_r, stamp_mid_nxt;
  logic [7:0] stamp_high_r, stamp_high_nxt;
  logic [7:0] window_r, window_nxt;
  logic [7:0] cross_r, cross_nxt;
  logic       upper_zone_r, upper_zone_nxt;
  logic [7:0] latched_r, latched_nxt;
  logic [7:0] target_r, target_nxt;
  logic [9:0] drive_r, drive_nxt;

  logic       out_valid_r;
  vfr_out_t   out_data_r;
  logic       emit;
  vfr_out_t   result;

  logic               carry_low, carry_mid;
  logic signed [10:0] lo_bound, hi_bound, lat_ext, drive_down;
  logic [10:0]        drive_up;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    running_nxt    = running_r;
    armed_nxt      = armed_r;
    pending_nxt    = pending_r;
    stamp_low_nxt  = stamp_low_r;
    stamp_mid_nxt  = stamp_mid_r;
    stamp_high_nxt = stamp_high_r;
    window_nxt     = window_r;
    cross_nxt      = cross_r;
    upper_zone_nxt = upper_zone_r;
    latched_nxt    = latched_r;
    target_nxt     = target_r;
    drive_nxt      = drive_r;
    emit           = 1'b0;
    result         = '0;
    carry_low      = 1'b0;
    carry_mid      = 1'b0;
    lo_bound   = $signed({3'b000, target_r}) - $signed({3'b000, cfg.band_tolerance});
    hi_bound   = $signed({3'b000, target_r}) + $signed({3'b000, cfg.band_tolerance});
    lat_ext    = '0;
    drive_down = $signed({1'b0, drive_r}) - $signed({3'b000, cfg.drive_step});
    drive_up   = {1'b0, drive_r} + {3'b000, cfg.drive_step};

    unique case (head_entry.op)
      OP_TICK: begin
        if (running_r) begin
          stamp_low_nxt = stamp_low_r + 8'd1;
          if (stamp_low_nxt == STAMP_WRAP) begin
            stamp_low_nxt = '0;
            carry_low     = 1'b1;
          end
          stamp_mid_nxt = stamp_mid_r + {7'd0, carry_low};
          if (stamp_mid_nxt == STAMP_WRAP) begin
            stamp_mid_nxt = '0;
            carry_mid     = 1'b1;
          end
          stamp_high_nxt = stamp_high_r + {7'd0, carry_mid};
          if (stamp_high_nxt == STAMP_WRAP) begin
            stamp_high_nxt = '0;
          end
          window_nxt = window_r + 8'd1;

          if ($signed(head_entry.accel_sample) >= $signed(cfg.upper_threshold)
              && upper_zone_r) begin
            cross_nxt      = cross_r + 8'd1;
            upper_zone_nxt = 1'b0;
          end else if ($signed(head_entry.accel_sample) <= $signed(cfg.lower_threshold)
                       && !upper_zone_r) begin
            cross_nxt      = cross_r + 8'd1;
            upper_zone_nxt = 1'b1;
          end

          if (window_nxt == cfg.ticks_per_window) begin
            latched_nxt = {1'b0, cross_nxt[7:1]};
            cross_nxt   = '0;
            window_nxt  = '0;
          end

          lat_ext = $signed({3'b000, latched_nxt});
          if (lat_ext < lo_bound) begin
            drive_nxt = (drive_down <= 0) ? cfg.drive_limit : drive_down[9:0];
          end else if (lat_ext > hi_bound) begin
            drive_nxt = (drive_up >= {1'b0, cfg.drive_limit}) ? '0 : drive_up[9:0];
          end

          emit                      = 1'b1;
          result.report_kind        = 1'b0;
          result.stamp_high         = stamp_high_nxt;
          result.stamp_mid          = stamp_mid_nxt;
          result.stamp_low          = stamp_low_nxt;
          result.sample_echo        = head_entry.accel_sample;
          result.measured_frequency = latched_nxt;
          result.drive_compare      = drive_nxt;
        end
      end
      OP_RUN_CTRL: begin
        if (running_r) begin
          running_nxt = 1'b0;
          armed_nxt   = 1'b0;
          drive_nxt   = cfg.drive_limit;
          if (pending_r) begin
            pending_nxt        = 1'b0;
            emit               = 1'b1;
            result.report_kind = 1'b1;
          end
        end else begin
          armed_nxt = 1'b1;
        end
      end
      OP_SENSOR: begin
        if (running_r) begin
          pending_nxt = 1'b1;
        end else begin
          emit               = 1'b1;
          result.report_kind = 1'b1;
        end
      end
      OP_TARGET: begin
        if (armed_r) begin
          running_nxt = 1'b1;
          target_nxt  = head_entry.command_byte;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      armed_r      <= 1'b0;
      pending_r    <= 1'b0;
      stamp_low_r  <= '0;
      stamp_mid_r  <= '0;
      stamp_high_r <= '0;
      window_r     <= '0;
      cross_r      <= '0;
      upper_zone_r <= 1'b1;
      latched_r    <= '0;
      target_r     <= '0;
      drive_r      <= DRIVE_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        running_r    <= running_nxt;
        armed_r      <= armed_nxt;
        pending_r    <= pending_nxt;
        stamp_low_r  <= stamp_low_nxt;
        stamp_mid_r  <= stamp_mid_nxt;
        stamp_high_r <= stamp_high_nxt;
        window_r     <= window_nxt;
        cross_r      <= cross_nxt;
        upper_zone_r <= upper_zone_nxt;
        latched_r    <= latched_nxt;
        target_r     <= target_nxt;
        drive_r      <= drive_nxt;
        out_valid_r  <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= result;
    end
  end

  a_notice_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.report_kind |->
      out_data_r.stamp_high == '0 && out_data_r.stamp_low == '0 &&
      out_data_r.sample_echo == '0 && out_data_r.drive_compare == '0)
    else $error("notice word carries nonzero fields");

  a_stamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    stamp_low_r != STAMP_WRAP && stamp_mid_r != STAMP_WRAP && stamp_high_r != STAMP_WRAP)
    else $error("timestamp byte reached wrap value");

  a_stop_resets_drive: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_entry.op == OP_RUN_CTRL && running_r |=>
      !running_r && drive_r == cfg.drive_limit)
    else $error("stop did not restore drive compare");

endmodule

### src/vibration_frequency_regulator.sv
`timescale 1ns / 1ps

// Port group   Handshake              Word
// in_          in_valid / in_stall    vfr_in_t: kind, command_byte, accel_sample
// out_         out_valid / out_stall  vfr_out_t: report and timestamp fields
// cfg_         cfg_wr_en              cfg_index selects, cfg_data holds the value
//
// One word is taken per cycle while in_stall is low; with an empty queue a word is
// written into the queue, then its result is registered in the output register.
// The input side stalls only when the queue is full, which happens when a result word
// is held in the output register by out_stall while QUEUE_DEPTH more words arrive.
// Reset is synchronous on rst_n and restores all but the queue slots and out_data.
// Words that produce no result still pass through the queue in order.
module vibration_frequency_regulator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  vfr_pkg::vfr_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output vfr_pkg::vfr_out_t                     out_data,
  input  logic                                  cfg_wr_en,
  input  logic [vfr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [vfr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import vfr_pkg::*;

  vfr_cfg_t   cfg_r;
  logic       q_full, q_push, q_pop, q_head_valid;
  vfr_entry_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_threshold  <= UPPER_THRESHOLD_RST;
      cfg_r.lower_threshold  <= LOWER_THRESHOLD_RST;
      cfg_r.ticks_per_window <= TICKS_PER_WINDOW_RST;
      cfg_r.drive_step       <= DRIVE_STEP_RST;
      cfg_r.drive_limit      <= DRIVE_LIMIT_RST;
      cfg_r.band_tolerance   <= BAND_TOLERANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_UPPER_THRESHOLD:  cfg_r.upper_threshold  <= cfg_data;
        REG_LOWER_THRESHOLD:  cfg_r.lower_threshold  <= cfg_data;
        REG_TICKS_PER_WINDOW: cfg_r.ticks_per_window <= cfg_data[7:0];
        REG_DRIVE_STEP:       cfg_r.drive_step       <= cfg_data[7:0];
        REG_DRIVE_LIMIT:      cfg_r.drive_limit      <= cfg_data[9:0];
        REG_BAND_TOLERANCE:   cfg_r.band_tolerance   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  vfr_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  vfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  vfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_data   (out_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
